### rtl/pfa_pkg.sv
// pfa_pkg: shared widths, codes and bit-search helpers of the page frame allocator.
// Depends on nothing; page_frame_allocator_top imports it.

package pfa_pkg;

    // Field and state widths
    localparam int unsigned FRAME_W    = 17;   // frame numbers up to and including 65536
    localparam int unsigned FRAME_IN_W = 16;
    localparam int unsigned COUNT_W    = 17;
    localparam int unsigned ACT_W      = 2;
    localparam int unsigned CFG_IDX_W  = 1;

    // Map word geometry
    localparam int unsigned WORD_BITS  = 32;
    localparam int unsigned WORD_LOG   = 5;
    localparam int unsigned WIDX_W     = FRAME_W - WORD_LOG;
    localparam logic [WORD_BITS-1:0] ONES = '1;

    // Frame space and parameter default
    localparam int unsigned FRAME_SPAN = 65536;
    localparam int unsigned FRAMES_DEF = 65536;
    localparam logic [FRAME_W-1:0] FRAME_HIGH_RST = FRAME_W'(FRAME_SPAN);

    // Action codes
    typedef enum logic [ACT_W-1:0] {
        ACT_INIT   = 2'd0,
        ACT_ENABLE = 2'd1,
        ACT_ALLOC  = 2'd2,
        ACT_FREE   = 2'd3
    } t_action;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HIGH = 1'b1;

    // Count of set bits from bit 0 upward until the first clear bit
    function automatic logic [WORD_LOG:0] trailing_ones(input logic [WORD_BITS-1:0] v);
        logic [WORD_LOG:0] n;
        logic              stop;
        n    = '0;
        stop = 1'b0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (!stop && v[i]) begin
                n = n + 1'b1;
            end else begin
                stop = 1'b1;
            end
        end
        return n;
    endfunction

    // Count of set bits from the top bit downward until the first clear bit
    function automatic logic [WORD_LOG:0] leading_ones(input logic [WORD_BITS-1:0] v);
        logic [WORD_LOG:0] n;
        logic              stop;
        n    = '0;
        stop = 1'b0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!stop && v[i]) begin
                n = n + 1'b1;
            end else begin
                stop = 1'b1;
            end
        end
        return n;
    endfunction

    // Position of the lowest set bit, zero when none is set
    function automatic logic [WORD_LOG-1:0] first_set(input logic [WORD_BITS-1:0] v);
        logic [WORD_LOG-1:0] pos;
        logic                found;
        pos   = '0;
        found = 1'b0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (!found && v[i]) begin
                pos   = WORD_LOG'(i);
                found = 1'b1;
            end
        end
        return pos;
    endfunction

endpackage

### rtl/page_frame_allocator_top.sv
// page_frame_allocator_top: bump and first-fit bitmap page frame allocator.
// Depends on pfa_pkg for widths, action codes and bit-search helpers.
//
//   channel   direction  handshake               payload
//   in        to block   i_in_valid / o_in_stall  i_action, i_frame, i_count
//   out       from block o_out_valid / i_out_stall o_granted, o_first_frame
//   cfg       to block   i_cfg_we                 i_cfg_index, i_cfg_data
//
// One item at a time; one map word of 32 frames goes through the shared scan unit per cycle.
// Bump allocate: accept, then respond. Map allocate: accept, scan words, then a read and a write
// per word marked, then respond. Free in map mode: a read and a write per word touched; no result.
// Init: no result. Enable: clears ceil(map frames / 32) words, one per cycle via the single write port.
// Reset is synchronous and returns to bump mode; the map is cleared by the next enable.
// A stalled result sits in the output register; the next item is taken meanwhile.

module page_frame_allocator_top
    import pfa_pkg::*;
#(
    parameter int unsigned FRAMES = FRAMES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [ACT_W-1:0]      i_action,
    input  logic [FRAME_IN_W-1:0] i_frame,
    input  logic [COUNT_W-1:0]    i_count,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_granted,
    output logic [FRAME_IN_W-1:0] o_first_frame,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [FRAME_W-1:0]    i_cfg_data
);

    // Map geometry; frames at or above the frame span are never handed out
    localparam int unsigned MAP_FRAMES = (FRAMES < FRAME_SPAN) ? FRAMES : FRAME_SPAN;
    localparam int unsigned NWORDS     = (MAP_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned ADDR_W     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam logic [FRAME_W-1:0] MAP_LIM   = FRAME_W'(MAP_FRAMES);
    localparam logic [WIDX_W-1:0]  LAST_WORD = WIDX_W'(NWORDS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_SCAN,
        S_RMW_RD,
        S_RMW_WR,
        S_RESP
    } t_state;

    t_state                r_state;
    logic [WIDX_W-1:0]     r_widx;
    logic [WIDX_W-1:0]     r_last_w;
    logic [FRAME_W-1:0]    r_hint;
    logic [FRAME_W-1:0]    r_bump;
    logic                  r_map_mode;
    logic [FRAME_W-1:0]    r_frame_low;
    logic [FRAME_W-1:0]    r_frame_high;
    logic [COUNT_W-1:0]    r_count;
    logic [COUNT_W-1:0]    r_run;
    logic [FRAME_W-1:0]    r_lo;
    logic [FRAME_W-1:0]    r_hi;
    logic                  r_set;
    logic                  r_res_granted;
    logic [FRAME_IN_W-1:0] r_res_first;
    logic                  r_out_valid;
    logic                  r_granted;
    logic [FRAME_IN_W-1:0] r_first;
    logic [WORD_BITS-1:0]  r_rd_data;
    logic [WORD_BITS-1:0]  mem [NWORDS];

    logic                  w_in_acc;
    logic                  w_out_free;
    logic [FRAME_W-1:0]    w_lim;
    logic [FRAME_W-1:0]    w_lim_m1;
    logic [ADDR_W-1:0]     w_rd_addr;
    logic                  w_mem_we;
    logic [WORD_BITS-1:0]  w_wr_data;

    // scan unit
    logic [FRAME_W-1:0]    w_base;
    logic [WORD_BITS-1:0]  w_lowmask;
    logic [WORD_BITS-1:0]  w_highmask;
    logic [WORD_BITS-1:0]  w_free;
    logic [WORD_LOG:0]     w_prefix;
    logic [COUNT_W-1:0]    w_need;
    logic                  w_hit_a;
    logic                  w_hit_b;
    logic                  w_hit;
    logic [WORD_BITS-1:0]  w_pow;
    logic [WORD_BITS-1:0]  w_acc;
    logic                  w_acc_started;
    logic [WORD_LOG-1:0]   w_j;
    logic [FRAME_W-1:0]    w_end;
    logic [FRAME_W-1:0]    w_start;
    logic [COUNT_W-1:0]    w_run_next;

    // bump and free checks
    logic                  w_bump_ok;
    logic [FRAME_W:0]      w_free_sum;
    logic [FRAME_W-1:0]    w_free_end;
    logic                  w_free_any;

    // read-modify-write mask
    logic [WORD_LOG-1:0]   w_lo_b;
    logic [WORD_LOG-1:0]   w_hi_b;
    logic [WORD_BITS-1:0]  w_mask;

    assign w_in_acc    = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_granted   = r_granted;
    assign o_first_frame = r_first;

    // Frame limit: smallest of frame_high and the map size
    assign w_lim    = (r_frame_high < MAP_LIM) ? r_frame_high : MAP_LIM;
    assign w_lim_m1 = w_lim - 1'b1;

    // Bump check
    assign w_bump_ok = (i_count != '0) && (r_bump <= w_lim)
                     && (i_count <= (w_lim - r_bump));

    // Free range, clipped to the map
    assign w_free_sum = {2'b00, i_frame} + {1'b0, i_count};
    assign w_free_end = (w_free_sum > {1'b0, MAP_LIM}) ? MAP_LIM : w_free_sum[FRAME_W-1:0];
    assign w_free_any = (i_count != '0) && ({1'b0, i_frame} < MAP_LIM);

    // Scan one map word: mask to [hint, limit), then look for a run
    always_comb begin
        w_base     = {r_widx, {WORD_LOG{1'b0}}};
        w_lowmask  = (r_widx == r_hint[FRAME_W-1:WORD_LOG])
                   ? (ONES << r_hint[WORD_LOG-1:0]) : ONES;
        w_highmask = (r_widx == r_last_w)
                   ? (ONES >> (WORD_LOG'(WORD_BITS - 1) - w_lim_m1[WORD_LOG-1:0])) : ONES;
        w_free     = ~r_rd_data & w_lowmask & w_highmask;
        w_prefix   = trailing_ones(w_free);

        // run carried in from earlier words
        w_need  = r_count - r_run;
        w_hit_a = (w_need <= COUNT_W'(w_prefix));

        // run inside this word: build windows of count free frames by doubling
        w_pow         = w_free;
        w_acc         = ONES;
        w_acc_started = 1'b0;
        for (int b = 0; b <= WORD_LOG; b++) begin
            if (r_count[b]) begin
                w_acc         = w_acc_started ? (w_pow & (w_acc << (1 << b))) : w_pow;
                w_acc_started = 1'b1;
            end
            w_pow = w_pow & (w_pow << (1 << b));
        end
        w_hit_b = (r_count <= COUNT_W'(WORD_BITS)) && (|w_acc);

        w_hit   = w_hit_a || w_hit_b;
        w_j     = w_hit_a ? WORD_LOG'(w_need - 1'b1) : first_set(w_acc);
        w_end   = w_base + FRAME_W'(w_j);
        w_start = w_end + 1'b1 - r_count;

        // run that continues into the next word
        w_run_next = (&w_free) ? (r_run + COUNT_W'(WORD_BITS)) : COUNT_W'(leading_ones(w_free));
    end

    // Mask of the frames of the current word that lie in [r_lo, r_hi]
    always_comb begin
        w_lo_b = (r_widx == r_lo[FRAME_W-1:WORD_LOG]) ? r_lo[WORD_LOG-1:0] : '0;
        w_hi_b = (r_widx == r_hi[FRAME_W-1:WORD_LOG]) ? r_hi[WORD_LOG-1:0]
                                                      : WORD_LOG'(WORD_BITS - 1);
        w_mask = (ONES << w_lo_b) & (ONES >> (WORD_LOG'(WORD_BITS - 1) - w_hi_b));
    end

    // Memory port selection
    always_comb begin
        case (r_state)
            S_IDLE:  w_rd_addr = r_hint[ADDR_W+WORD_LOG-1:WORD_LOG];
            S_SCAN:  w_rd_addr = ADDR_W'(r_widx + 1'b1);
            default: w_rd_addr = r_widx[ADDR_W-1:0];
        endcase
        w_mem_we  = (r_state == S_CLEAR) || (r_state == S_RMW_WR);
        w_wr_data = (r_state == S_CLEAR) ? '0
                  : (r_set ? (r_rd_data | w_mask) : (r_rd_data & ~w_mask));
    end

    // Used map: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[r_widx[ADDR_W-1:0]] <= w_wr_data;
        end
        r_rd_data <= mem[w_rd_addr];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_low  <= '0;
            r_frame_high <= FRAME_HIGH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_LOW:  r_frame_low  <= i_cfg_data;
                CFG_FRAME_HIGH: r_frame_high <= i_cfg_data;
                default:        r_frame_low  <= r_frame_low;
            endcase
        end
    end

    // Sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_map_mode  <= 1'b0;
            r_hint      <= '0;
            r_bump      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop a result beat once it is taken, unless a new one replaces it
            if (r_out_valid && !i_out_stall && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (t_action'(i_action))
                            ACT_INIT: begin
                                r_bump     <= r_frame_low;
                                r_hint     <= r_frame_low;
                                r_map_mode <= 1'b0;
                            end
                            ACT_ENABLE: begin
                                r_hint     <= r_bump;
                                r_map_mode <= 1'b1;
                                r_widx     <= '0;
                                r_state    <= S_CLEAR;
                            end
                            ACT_ALLOC: begin
                                r_count <= i_count;
                                if (r_map_mode) begin
                                    r_res_granted <= 1'b0;
                                    r_res_first   <= '0;
                                    if ((i_count == '0) || (r_hint >= w_lim)) begin
                                        r_state <= S_RESP;
                                    end else begin
                                        r_widx   <= r_hint[FRAME_W-1:WORD_LOG];
                                        r_last_w <= w_lim_m1[FRAME_W-1:WORD_LOG];
                                        r_run    <= '0;
                                        r_state  <= S_SCAN;
                                    end
                                end else begin
                                    if (w_bump_ok) begin
                                        r_res_granted <= 1'b1;
                                        r_res_first   <= r_bump[FRAME_IN_W-1:0];
                                        r_bump        <= r_bump + i_count;
                                        r_hint        <= r_bump + i_count;
                                    end else begin
                                        r_res_granted <= 1'b0;
                                        r_res_first   <= '0;
                                    end
                                    r_state <= S_RESP;
                                end
                            end
                            ACT_FREE: begin
                                if (r_map_mode) begin
                                    if ({1'b0, i_frame} < r_hint) begin
                                        r_hint <= {1'b0, i_frame};
                                    end
                                    if (w_free_any) begin
                                        r_lo    <= {1'b0, i_frame};
                                        r_hi    <= w_free_end - 1'b1;
                                        r_set   <= 1'b0;
                                        r_widx  <= WIDX_W'(i_frame >> WORD_LOG);
                                        r_state <= S_RMW_RD;
                                    end
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end

                S_CLEAR: begin
                    if (r_widx == LAST_WORD) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_widx <= r_widx + 1'b1;
                    end
                end

                S_SCAN: begin
                    if (w_hit) begin
                        r_lo          <= w_start;
                        r_hi          <= w_end;
                        r_set         <= 1'b1;
                        r_widx        <= w_start[FRAME_W-1:WORD_LOG];
                        r_hint        <= w_end + 1'b1;
                        r_res_granted <= 1'b1;
                        r_res_first   <= w_start[FRAME_IN_W-1:0];
                        r_state       <= S_RMW_RD;
                    end else if (r_widx == r_last_w) begin
                        r_state <= S_RESP;
                    end else begin
                        r_run  <= w_run_next;
                        r_widx <= r_widx + 1'b1;
                    end
                end

                S_RMW_RD: begin
                    r_state <= S_RMW_WR;
                end

                S_RMW_WR: begin
                    if (r_widx == r_hi[FRAME_W-1:WORD_LOG]) begin
                        r_state <= r_set ? S_RESP : S_IDLE;
                    end else begin
                        r_widx  <= r_widx + 1'b1;
                        r_state <= S_RMW_RD;
                    end
                end

                S_RESP: begin
                    // hold until the output register is free
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_granted   <= r_res_granted;
                        r_first     <= r_res_first;
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Checks on the sequencer
    a_run_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_run < r_count))
        else $error("scan run reached count without a hit");

    a_rmw_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMW_WR) |-> ((r_widx >= r_lo[FRAME_W-1:WORD_LOG])
                                   && (r_widx <= r_hi[FRAME_W-1:WORD_LOG])))
        else $error("map write outside the marked run");

    a_out_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_RESP))
        else $error("result beat raised outside the response state");

    a_enable_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (t_action'(i_action) == ACT_ENABLE)) |=> ((r_state == S_CLEAR) && r_map_mode))
        else $error("enable did not start the clearing pass");

endmodule
